// File: rtl/fbpa_pkg.sv
// Shared constants and types of the fixed block pool allocator.
package fbpa_pkg;

  localparam int unsigned MAX_UNITS = 512;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SIZE_W = 12;
  localparam int unsigned UCNT_W = 10;
  localparam int unsigned IDX_W  = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_UNITS + 1);
  localparam int unsigned OFF_W  = IDX_W + SIZE_W;
  localparam int unsigned LIM_W  = CNT_W + SIZE_W;

  // Quotient bits resolved per cycle by the divider.
  localparam int unsigned DIV_PER_CYC = 3;
  localparam int unsigned STEP_W      = $clog2(IDX_W + DIV_PER_CYC + 1);

  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_DATA_BASE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_UNIT_SIZE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_UNIT_COUNT = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [ADDR_W-1:0] RST_DATA_BASE  = 32'd0;
  localparam logic [SIZE_W-1:0] RST_UNIT_SIZE  = 12'd8;
  localparam logic [UCNT_W-1:0] RST_UNIT_COUNT = 10'd256;

  // One entry of the unit memory: allocated mark and free-list successor.
  typedef struct packed {
    logic             mark;
    logic             lfresh;
    logic [IDX_W-1:0] link;
  } unit_ent_t;

endpackage

// File: rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: control, divider and unit memory.
//
// The pool hands out fixed-size units from a LIFO free list kept in one
// synchronous unit memory (one write and one read port, registered read data)
// that holds, per unit, an allocated mark and the free-list successor. An
// allocate transfer answers data_base + index * unit_size with ok set, or
// address 0 with ok clear when the pool is empty. A free transfer succeeds only
// for a nonzero address that is exactly the address of a managed unit marked
// allocated; the unit then goes back onto the head of the free list. Every
// transfer gives exactly one result with the count of units in use after it.
// Writing any configuration register returns the pool to all free at once:
// a fresh-unit counter hands out units 0, 1, 2, ... in order, and marks of
// units at or above that counter read as clear, so no clearing pass is needed.
// One item is in work at a time. An allocate from the fresh counter passes
// through S_MUL, S_ADD and S_OUT before its result is loaded; an allocate from
// the free list first passes S_POP, which takes the successor read from memory.
// A free passes S_CHK, then the divider in S_DIV that finds the unit index three
// quotient bits per cycle, then S_FRD and S_FCHK for the read-modify-write of
// the unit's entry, and S_OUT. The input is ready again in the cycle after the
// result enters the output register, even while that result still waits to be
// taken.
module fixed_block_pool_allocator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]      free_addr_i,
  // Result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [fbpa_pkg::ADDR_W-1:0]      alloc_addr_o,
  output logic                             ok_o,
  output logic [fbpa_pkg::UCNT_W-1:0]      used_count_o,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fbpa_pkg::PADDR_W-1:0]     paddr,
  input  logic [fbpa_pkg::PDATA_W-1:0]     pwdata,
  output logic [fbpa_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_MUL,
    S_ADD,
    S_CHK,
    S_DIV,
    S_FRD,
    S_FCHK,
    S_OUT
  } state_e;

  localparam int unsigned IDX_W  = fbpa_pkg::IDX_W;
  localparam int unsigned CNT_W  = fbpa_pkg::CNT_W;
  localparam int unsigned SIZE_W = fbpa_pkg::SIZE_W;
  localparam int unsigned ADDR_W = fbpa_pkg::ADDR_W;
  localparam int unsigned OFF_W  = fbpa_pkg::OFF_W;
  localparam int unsigned LIM_W  = fbpa_pkg::LIM_W;
  localparam int unsigned STEP_W = fbpa_pkg::STEP_W;

  state_e state_q;

  // Configuration registers.
  logic [ADDR_W-1:0]           data_base_q;
  logic [SIZE_W-1:0]           unit_size_q;
  logic [fbpa_pkg::UCNT_W-1:0] unit_count_q;

  // Pool control state.
  logic [IDX_W-1:0] head_q;
  logic             head_fresh_q;
  logic [CNT_W-1:0] fresh_q;
  logic [CNT_W-1:0] used_q;

  // Per-item work registers.
  logic [IDX_W-1:0]  idx_q;
  logic [OFF_W-1:0]  prod_q;
  logic [ADDR_W-1:0] off_q;
  logic              addr_zero_q;
  logic [LIM_W-1:0]  limit_q;
  logic [SIZE_W-1:0] rem_q;
  logic [IDX_W-1:0]  dvd_q;
  logic [IDX_W-1:0]  q_q;
  logic [STEP_W-1:0] step_q;
  logic [ADDR_W-1:0] res_addr_q;
  logic              res_ok_q;

  // Output register.
  logic                        out_valid_q;
  logic [ADDR_W-1:0]           out_addr_q;
  logic                        out_ok_q;
  logic [fbpa_pkg::UCNT_W-1:0] out_used_q;

  // Unit memory.
  fbpa_pkg::unit_ent_t unit_mem_q [fbpa_pkg::MAX_UNITS];
  fbpa_pkg::unit_ent_t mem_rdata_q;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  fbpa_pkg::unit_ent_t mem_wdata;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_raddr;

  logic [SIZE_W-1:0] size_eff;
  logic [CNT_W-1:0]  count_eff;
  logic              fresh_avail;
  logic              q_live;
  logic              in_fire;
  logic              cfg_wr;
  logic [fbpa_pkg::REG_IDX_W-1:0] cfg_idx;

  logic [SIZE_W-1:0] rem_n;
  logic [IDX_W-1:0]  dvd_n;
  logic [IDX_W-1:0]  q_n;
  logic [SIZE_W:0]   trial;
  logic              div_last;

  assign in_ready_o   = (state_q == S_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign alloc_addr_o = out_addr_q;
  assign ok_o         = out_ok_q;
  assign used_count_o = out_used_q;

  // The port never inserts wait states.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[fbpa_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      fbpa_pkg::REG_DATA_BASE:  prdata = data_base_q;
      fbpa_pkg::REG_UNIT_SIZE:  prdata = fbpa_pkg::PDATA_W'(unit_size_q);
      fbpa_pkg::REG_UNIT_COUNT: prdata = fbpa_pkg::PDATA_W'(unit_count_q);
      default:                  prdata = '0;
    endcase
  end

  // A zero size acts as one byte; a count above the pool capacity saturates.
  assign size_eff  = (unit_size_q == '0) ? SIZE_W'(1) : unit_size_q;
  assign count_eff = (32'(unit_count_q) > 32'(fbpa_pkg::MAX_UNITS)) ?
                     CNT_W'(fbpa_pkg::MAX_UNITS) : CNT_W'(unit_count_q);

  assign fresh_avail = (fresh_q < count_eff);
  // Units at or above the fresh counter were never handed out since the
  // last clear, so their marks read as clear whatever the memory holds.
  assign q_live = (CNT_W'(q_q) < fresh_q);

  // Restoring division, DIV_PER_CYC quotient bits per cycle. The remainder
  // starts as the offset bits above the quotient field, which is known to be
  // below the size because the offset was checked against count * size.
  always_comb begin
    rem_n = rem_q;
    dvd_n = dvd_q;
    q_n   = q_q;
    trial = '0;
    for (int j = 0; j < int'(fbpa_pkg::DIV_PER_CYC); j++) begin
      if (int'(step_q) + j < int'(IDX_W)) begin
        trial = {rem_n, dvd_n[IDX_W-1]};
        dvd_n = dvd_n << 1;
        if (trial >= (SIZE_W + 1)'(size_eff)) begin
          rem_n = SIZE_W'(trial - (SIZE_W + 1)'(size_eff));
          q_n   = IDX_W'({q_n, 1'b1});
        end else begin
          rem_n = trial[SIZE_W-1:0];
          q_n   = IDX_W'({q_n, 1'b0});
        end
      end
    end
  end

  assign div_last = (int'(step_q) + int'(fbpa_pkg::DIV_PER_CYC) >= int'(IDX_W));

  // Unit memory access control: an item reads and writes back at most its own entry.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = mem_rdata_q;
    mem_re    = 1'b0;
    mem_raddr = head_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (op_i == fbpa_pkg::OP_ALLOC)) begin
          if (head_fresh_q) begin
            mem_we         = fresh_avail;
            mem_waddr      = fresh_q[IDX_W-1:0];
            mem_wdata      = '0;
            mem_wdata.mark = 1'b1;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = head_q;
          end
        end
      end
      S_POP: begin
        mem_we         = 1'b1;
        mem_waddr      = idx_q;
        mem_wdata      = mem_rdata_q;
        mem_wdata.mark = 1'b1;
      end
      S_FRD: begin
        mem_re    = (rem_q == '0) && q_live;
        mem_raddr = q_q;
      end
      S_FCHK: begin
        mem_we           = mem_rdata_q.mark;
        mem_waddr        = q_q;
        mem_wdata.mark   = 1'b0;
        mem_wdata.lfresh = head_fresh_q;
        mem_wdata.link   = head_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      unit_mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= unit_mem_q[mem_raddr];
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    limit_q <= LIM_W'(count_eff) * LIM_W'(size_eff);
    if (in_fire) begin
      off_q       <= free_addr_i - data_base_q;
      addr_zero_q <= (free_addr_i == '0);
    end
    if (state_q == S_MUL) begin
      prod_q <= OFF_W'(idx_q) * OFF_W'(size_eff);
    end
  end

  // Controller: state, pool bookkeeping, configuration and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      data_base_q  <= fbpa_pkg::RST_DATA_BASE;
      unit_size_q  <= fbpa_pkg::RST_UNIT_SIZE;
      unit_count_q <= fbpa_pkg::RST_UNIT_COUNT;
      head_q       <= '0;
      head_fresh_q <= 1'b1;
      fresh_q      <= '0;
      used_q       <= '0;
      idx_q        <= '0;
      rem_q        <= '0;
      dvd_q        <= '0;
      q_q          <= '0;
      step_q       <= '0;
      res_addr_q   <= '0;
      res_ok_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_addr_q   <= '0;
      out_ok_q     <= 1'b0;
      out_used_q   <= '0;
    end else begin
      // The output register empties on a result transfer unless a new
      // result is loaded in the same cycle.
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            res_addr_q <= '0;
            res_ok_q   <= 1'b0;
            if (op_i == fbpa_pkg::OP_ALLOC) begin
              if (head_fresh_q) begin
                if (fresh_avail) begin
                  idx_q   <= fresh_q[IDX_W-1:0];
                  fresh_q <= fresh_q + CNT_W'(1);
                  used_q  <= used_q + CNT_W'(1);
                  state_q <= S_MUL;
                end else begin
                  state_q <= S_OUT;
                end
              end else begin
                idx_q   <= head_q;
                state_q <= S_POP;
              end
            end else begin
              state_q <= S_CHK;
            end
          end
        end
        S_POP: begin
          head_q       <= mem_rdata_q.link;
          head_fresh_q <= mem_rdata_q.lfresh;
          used_q       <= used_q + CNT_W'(1);
          state_q      <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_ADD;
        end
        S_ADD: begin
          res_addr_q <= data_base_q + ADDR_W'(prod_q);
          res_ok_q   <= 1'b1;
          state_q    <= S_OUT;
        end
        S_CHK: begin
          if (addr_zero_q || (off_q >= ADDR_W'(limit_q))) begin
            state_q <= S_OUT;
          end else begin
            rem_q   <= off_q[OFF_W-1:IDX_W];
            dvd_q   <= off_q[IDX_W-1:0];
            q_q     <= '0;
            step_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q  <= rem_n;
          dvd_q  <= dvd_n;
          q_q    <= q_n;
          step_q <= step_q + STEP_W'(fbpa_pkg::DIV_PER_CYC);
          if (div_last) begin
            state_q <= S_FRD;
          end
        end
        S_FRD: begin
          if ((rem_q == '0) && q_live) begin
            state_q <= S_FCHK;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_FCHK: begin
          if (mem_rdata_q.mark) begin
            head_q       <= q_q;
            head_fresh_q <= 1'b0;
            if (used_q != '0) begin
              used_q <= used_q - CNT_W'(1);
            end
            res_ok_q <= 1'b1;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_addr_q  <= res_addr_q;
            out_ok_q    <= res_ok_q;
            out_used_q  <= fbpa_pkg::UCNT_W'(used_q);
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // A register write puts the whole pool back to all free.
      if (cfg_wr) begin
        unique case (cfg_idx)
          fbpa_pkg::REG_DATA_BASE: begin
            data_base_q  <= pwdata;
            head_q       <= '0;
            head_fresh_q <= 1'b1;
            fresh_q      <= '0;
            used_q       <= '0;
          end
          fbpa_pkg::REG_UNIT_SIZE: begin
            unit_size_q  <= pwdata[SIZE_W-1:0];
            head_q       <= '0;
            head_fresh_q <= 1'b1;
            fresh_q      <= '0;
            used_q       <= '0;
          end
          fbpa_pkg::REG_UNIT_COUNT: begin
            unit_count_q <= pwdata[fbpa_pkg::UCNT_W-1:0];
            head_q       <= '0;
            head_fresh_q <= 1'b1;
            fresh_q      <= '0;
            used_q       <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/fbpa_checker.sv
// Port-level assertions for the fixed block pool allocator and their binding.
module fbpa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [fbpa_pkg::ADDR_W-1:0]  alloc_addr_o,
  input logic                         ok_o,
  input logic [fbpa_pkg::UCNT_W-1:0]  used_count_o,
  input logic                         pready
);

  // A result without success (a failed allocate or free) reports address zero.
  a_fail_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> alloc_addr_o == '0)
    else $error("result without success carries a nonzero address");

  // A successful allocate leaves at least one unit in use.
  a_alloc_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ok_o && (alloc_addr_o != '0) |-> used_count_o != '0)
    else $error("successful allocate reports no unit in use");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(alloc_addr_o) && $stable(ok_o) && $stable(used_count_o))
    else $error("stalled result changed");

  // The configuration port never inserts wait states.
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("configuration port inserted a wait state");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
